// ===== design/range_add_range_max_tree_top_macros.svh =====
// ----------------------------------------------------------------------------
// range_add_range_max_tree_top_macros
// Assertion macros for the range-add / range-max tree. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef RANGE_ADD_RANGE_MAX_TREE_TOP_MACROS_SVH
`define RANGE_ADD_RANGE_MAX_TREE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// property that holds at every edge out of reset
`define RART_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("rart assertion failed");
// consequence in the cycle after the antecedent
`define RART_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rart assertion failed");
`else
`define RART_ASSERT(lbl, prop)
`define RART_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/rart_pkg.sv =====
// ----------------------------------------------------------------------------
// rart_pkg
// Shared types and constants of the range-add / range-max tree.
// ----------------------------------------------------------------------------
package rart_pkg;

	localparam int unsigned MaxLeavesDef = 1024;
	localparam int unsigned ValueBitsDef = 64;
	localparam int IdxW = 11;
	localparam logic [IdxW-1:0] LenReset = 11'd1024;
	// -1e18 in 64-bit two's complement
	localparam logic [63:0] EmptyMark = 64'hF21F_494C_589C_0000;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_VISIT, ST_COV_ADD, ST_COV_QRY,
		ST_PUSH1, ST_PUSH2, ST_PUSH3, ST_PULL1, ST_PULL2, ST_RESULT
	} state_t;

	// what a frame does next when it is on top
	typedef enum logic [1:0] {PH_ENTER, PH_AFTER_LEFT, PH_AFTER_RIGHT} phase_t;

	typedef enum logic [1:0] {RD_SELF, RD_LEFT, RD_RIGHT} rd_sel_t;
	typedef enum logic {MW_PUSH, MW_PULL} max_wsel_t;
	typedef enum logic [1:0] {PW_COVER, PW_ZERO, PW_LEFT, PW_RIGHT} pend_wsel_t;

	typedef struct packed {
		rd_sel_t    rd_sel;
		logic       max_we;
		max_wsel_t  max_wsel;
		logic       pend_we;
		pend_wsel_t pend_wsel;
		logic       start;
		logic       clear_step;
		logic       load_p;
		logic       load_ta;
		logic       upd_best;
		logic       push_left;
		logic       push_right;
		logic       pop;
		logic       load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic   clear_last;
		logic   start_ok;
		logic   disjoint;
		logic   covered;
		phase_t phase;
		logic   op_query;
		logic   stack_empty;
		logic   out_free;
	} dp_status_t;

endpackage

// ===== design/rart_ram.sv =====
// ----------------------------------------------------------------------------
// rart_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rart_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== design/rart_ctrl.sv =====
// ----------------------------------------------------------------------------
// rart_ctrl
// Sequencer: walks the tree one node step at a time, issuing datapath commands.
// ----------------------------------------------------------------------------
module rart_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 operation,
	output logic                 in_stall,
	input  rart_pkg::dp_status_t sts,
	output rart_pkg::dp_cmd_t    cmd
);

	rart_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rart_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		rart_pkg::state_t pop_next;
		pop_next = sts.stack_empty ?
			(sts.op_query ? rart_pkg::ST_RESULT : rart_pkg::ST_IDLE) : rart_pkg::ST_VISIT;
		state_d        = state_q;
		in_stall       = 1'b1;
		cmd            = '0;
		cmd.rd_sel     = rart_pkg::RD_SELF;
		cmd.max_wsel   = rart_pkg::MW_PUSH;
		cmd.pend_wsel  = rart_pkg::PW_ZERO;
		unique case (state_q)
			rart_pkg::ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) state_d = rart_pkg::ST_IDLE;
			end
			rart_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					if (sts.start_ok) state_d = rart_pkg::ST_VISIT;
					else if (operation == rart_pkg::OP_QUERY) state_d = rart_pkg::ST_RESULT;
				end
			end
			rart_pkg::ST_VISIT: begin
				unique case (sts.phase)
					rart_pkg::PH_ENTER: begin
						if (sts.disjoint) begin
							cmd.pop = 1'b1;
							state_d = pop_next;
						end else if (sts.covered) begin
							state_d = sts.op_query ? rart_pkg::ST_COV_QRY : rart_pkg::ST_COV_ADD;
						end else begin
							state_d = rart_pkg::ST_PUSH1;
						end
					end
					rart_pkg::PH_AFTER_LEFT: begin
						cmd.push_right = 1'b1;
					end
					rart_pkg::PH_AFTER_RIGHT: begin
						if (sts.op_query) begin
							cmd.pop = 1'b1;
							state_d = pop_next;
						end else begin
							cmd.rd_sel = rart_pkg::RD_LEFT;
							state_d = rart_pkg::ST_PULL1;
						end
					end
					default: begin
						state_d = rart_pkg::ST_IDLE;
					end
				endcase
			end
			rart_pkg::ST_COV_ADD: begin
				cmd.pend_we   = 1'b1;
				cmd.pend_wsel = rart_pkg::PW_COVER;
				cmd.pop       = 1'b1;
				state_d       = pop_next;
			end
			rart_pkg::ST_COV_QRY: begin
				cmd.upd_best = 1'b1;
				cmd.pop      = 1'b1;
				state_d      = pop_next;
			end
			// push_down: own node first, then the two children one per cycle
			rart_pkg::ST_PUSH1: begin
				cmd.max_we    = 1'b1;
				cmd.max_wsel  = rart_pkg::MW_PUSH;
				cmd.pend_we   = 1'b1;
				cmd.pend_wsel = rart_pkg::PW_ZERO;
				cmd.load_p    = 1'b1;
				cmd.rd_sel    = rart_pkg::RD_LEFT;
				state_d       = rart_pkg::ST_PUSH2;
			end
			rart_pkg::ST_PUSH2: begin
				cmd.pend_we   = 1'b1;
				cmd.pend_wsel = rart_pkg::PW_LEFT;
				cmd.rd_sel    = rart_pkg::RD_RIGHT;
				state_d       = rart_pkg::ST_PUSH3;
			end
			rart_pkg::ST_PUSH3: begin
				cmd.pend_we   = 1'b1;
				cmd.pend_wsel = rart_pkg::PW_RIGHT;
				cmd.push_left = 1'b1;
				state_d       = rart_pkg::ST_VISIT;
			end
			rart_pkg::ST_PULL1: begin
				cmd.load_ta = 1'b1;
				cmd.rd_sel  = rart_pkg::RD_RIGHT;
				state_d     = rart_pkg::ST_PULL2;
			end
			rart_pkg::ST_PULL2: begin
				cmd.max_we   = 1'b1;
				cmd.max_wsel = rart_pkg::MW_PULL;
				cmd.pop      = 1'b1;
				state_d      = pop_next;
			end
			rart_pkg::ST_RESULT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = rart_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rart_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/rart_datapath.sv =====
// ----------------------------------------------------------------------------
// rart_datapath
// Node memories, frame stack, item registers, arithmetic and result register.
// ----------------------------------------------------------------------------
`include "range_add_range_max_tree_top_macros.svh"

module rart_datapath #(
	parameter int unsigned MAX_LEAVES = rart_pkg::MaxLeavesDef,
	parameter int unsigned VALUE_BITS = rart_pkg::ValueBitsDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rart_pkg::dp_cmd_t         cmd,
	output rart_pkg::dp_status_t      sts,
	input  logic                      cfg_wr_en,
	input  logic [rart_pkg::IdxW-1:0] cfg_wr_data,
	input  logic                      operation,
	input  logic [rart_pkg::IdxW-1:0] range_low,
	input  logic [rart_pkg::IdxW-1:0] range_high,
	input  logic [63:0]               add_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [63:0]               max_value,
	output logic                      range_empty
);

	localparam int IW    = rart_pkg::IdxW;
	localparam int VB    = int'(VALUE_BITS);
	localparam int Depth = 2 * MAX_LEAVES;
	localparam int AW    = $clog2(Depth);
	localparam int NW    = $clog2(4 * MAX_LEAVES);
	localparam int SD    = $clog2(MAX_LEAVES) + 2;
	localparam int SPW   = $clog2(SD + 1);
	localparam int SIW   = $clog2(SD);

	// configuration and item
	logic [IW-1:0] active_len_q;
	logic          op_q;
	logic [IW-1:0] lo_q, hi_q;
	logic [VB-1:0] v_q;

	// current frame and parent stack
	logic [NW-1:0]     cur_o_q;
	logic [IW-1:0]     cur_l_q, cur_r_q;
	rart_pkg::phase_t  cur_ph_q;
	logic [NW-1:0]     stk_o_q [SD];
	logic [IW-1:0]     stk_l_q [SD];
	logic [IW-1:0]     stk_r_q [SD];
	rart_pkg::phase_t  stk_ph_q [SD];
	logic [SPW-1:0]    sp_q;
	logic [SPW-1:0]    sp_dec;

	logic [AW-1:0] clr_q;
	logic [VB-1:0] p_q, ta_q, best_q;
	logic          found_q;
	logic          rd_ok_q;

	logic          out_valid_q;
	logic [63:0]   out_value_q;
	logic          out_empty_q;

	// memory ports
	logic [VB-1:0] max_rd, pend_rd, max_d, pend_d;
	logic [NW-1:0] raddr, paddr;
	logic [VB-1:0] max_wdata, pend_wdata, pend_wval;
	logic          max_we, pend_we;
	logic [AW-1:0] max_waddr, pend_waddr;

	// derived
	logic [IW-1:0] n_cfg, a_in, b_in, mid;
	logic [IW:0]   lr_sum;
	logic [NW-1:0] o_left, o_right;
	logic [VB-1:0] sum_mp, empty_w;

	assign n_cfg  = (32'(active_len_q) > MAX_LEAVES) ? IW'(MAX_LEAVES) : active_len_q;
	assign a_in   = (range_low == '0) ? IW'(1) : range_low;
	assign b_in   = (range_high > n_cfg) ? n_cfg : range_high;
	assign lr_sum = {1'b0, cur_l_q} + {1'b0, cur_r_q};
	assign mid    = lr_sum[IW:1];
	assign o_left  = {cur_o_q[NW-2:0], 1'b0};
	assign o_right = {cur_o_q[NW-2:0], 1'b1};
	assign sp_dec  = sp_q - 1'b1;
	assign empty_w = rart_pkg::EmptyMark[VB-1:0];

	// nodes past the end of memory read as zero
	assign max_d  = rd_ok_q ? max_rd : '0;
	assign pend_d = rd_ok_q ? pend_rd : '0;
	assign sum_mp = max_d + pend_d;

	always_comb begin
		case (cmd.rd_sel)
			rart_pkg::RD_LEFT:  raddr = o_left;
			rart_pkg::RD_RIGHT: raddr = o_right;
			default:            raddr = cur_o_q;
		endcase
	end

	always_comb begin
		case (cmd.pend_wsel)
			rart_pkg::PW_COVER: begin paddr = cur_o_q; pend_wval = pend_d + v_q; end
			rart_pkg::PW_LEFT:  begin paddr = o_left;  pend_wval = pend_d + p_q; end
			rart_pkg::PW_RIGHT: begin paddr = o_right; pend_wval = pend_d + p_q; end
			default:            begin paddr = cur_o_q; pend_wval = '0; end
		endcase
	end

	always_comb begin
		logic [VB-1:0] pulled;
		pulled = ($signed(sum_mp) > $signed(ta_q)) ? sum_mp : ta_q;
		if (cmd.clear_step) begin
			max_we     = 1'b1;
			pend_we    = 1'b1;
			max_waddr  = clr_q;
			pend_waddr = clr_q;
			max_wdata  = '0;
			pend_wdata = '0;
		end else begin
			max_we     = cmd.max_we && (32'(cur_o_q) < Depth);
			pend_we    = cmd.pend_we && (32'(paddr) < Depth);
			max_waddr  = cur_o_q[AW-1:0];
			pend_waddr = paddr[AW-1:0];
			max_wdata  = (cmd.max_wsel == rart_pkg::MW_PULL) ? pulled : sum_mp;
			pend_wdata = pend_wval;
		end
	end

	rart_ram #(.WIDTH(VB), .DEPTH(Depth)) u_max_ram (
		.clk     (clk),
		.wr_en   (max_we),
		.wr_addr (max_waddr),
		.wr_data (max_wdata),
		.rd_addr (raddr[AW-1:0]),
		.rd_data (max_rd)
	);

	rart_ram #(.WIDTH(VB), .DEPTH(Depth)) u_pend_ram (
		.clk     (clk),
		.wr_en   (pend_we),
		.wr_addr (pend_waddr),
		.wr_data (pend_wdata),
		.rd_addr (raddr[AW-1:0]),
		.rd_data (pend_rd)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_len_q <= rart_pkg::LenReset;
			clr_q        <= '0;
			sp_q         <= '0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			cur_ph_q     <= rart_pkg::PH_ENTER;
		end else begin
			if (cfg_wr_en) active_len_q <= cfg_wr_data;
			if (cmd.clear_step) clr_q <= clr_q + 1'b1;
			if (cmd.start) begin
				sp_q     <= '0;
				found_q  <= 1'b0;
				cur_ph_q <= rart_pkg::PH_ENTER;
			end else if (cmd.push_left || cmd.push_right) begin
				sp_q     <= sp_q + 1'b1;
				cur_ph_q <= rart_pkg::PH_ENTER;
			end else if (cmd.pop && sp_q != '0) begin
				sp_q     <= sp_dec;
				cur_ph_q <= stk_ph_q[sp_dec[SIW-1:0]];
			end
			if (cmd.upd_best) found_q <= 1'b1;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		rd_ok_q <= 32'(raddr) < Depth;
		if (cmd.start) begin
			op_q    <= operation;
			lo_q    <= range_low;
			hi_q    <= range_high;
			v_q     <= add_value[VB-1:0];
			cur_o_q <= NW'(1);
			cur_l_q <= IW'(1);
			cur_r_q <= n_cfg;
		end else if (cmd.push_left) begin
			stk_o_q[sp_q[SIW-1:0]]  <= cur_o_q;
			stk_l_q[sp_q[SIW-1:0]]  <= cur_l_q;
			stk_r_q[sp_q[SIW-1:0]]  <= cur_r_q;
			stk_ph_q[sp_q[SIW-1:0]] <= rart_pkg::PH_AFTER_LEFT;
			cur_o_q <= o_left;
			cur_r_q <= mid;
		end else if (cmd.push_right) begin
			stk_o_q[sp_q[SIW-1:0]]  <= cur_o_q;
			stk_l_q[sp_q[SIW-1:0]]  <= cur_l_q;
			stk_r_q[sp_q[SIW-1:0]]  <= cur_r_q;
			stk_ph_q[sp_q[SIW-1:0]] <= rart_pkg::PH_AFTER_RIGHT;
			cur_o_q <= o_right;
			cur_l_q <= mid + 1'b1;
		end else if (cmd.pop && sp_q != '0) begin
			cur_o_q <= stk_o_q[sp_dec[SIW-1:0]];
			cur_l_q <= stk_l_q[sp_dec[SIW-1:0]];
			cur_r_q <= stk_r_q[sp_dec[SIW-1:0]];
		end
		if (cmd.load_p) p_q <= pend_d;
		if (cmd.load_ta) ta_q <= sum_mp;
		if (cmd.upd_best && (!found_q || $signed(sum_mp) > $signed(best_q))) best_q <= sum_mp;
		if (cmd.load_out) begin
			out_value_q <= found_q ? 64'($signed(best_q)) : 64'($signed(empty_w));
			out_empty_q <= !found_q;
		end
	end

	assign sts.clear_last  = (32'(clr_q) == Depth - 1);
	assign sts.start_ok    = (n_cfg != '0) &&
		((operation == rart_pkg::OP_ADD) || (a_in <= b_in));
	assign sts.disjoint    = (hi_q < cur_l_q) || (lo_q > cur_r_q);
	assign sts.covered     = (cur_l_q >= lo_q) && (cur_r_q <= hi_q);
	assign sts.phase       = cur_ph_q;
	assign sts.op_query    = (op_q == rart_pkg::OP_QUERY);
	assign sts.stack_empty = (sp_q == '0);
	assign sts.out_free    = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign max_value   = out_value_q;
	assign range_empty = out_empty_q;

	`RART_ASSERT(a_sp_bound, sp_q <= SPW'(SD))
	`RART_ASSERT(a_push_room, (cmd.push_left || cmd.push_right) |-> (sp_q < SPW'(SD)))
	`RART_ASSERT(a_no_overwrite, (out_valid_q && out_stall) |-> !cmd.load_out)
	`RART_ASSERT_NEXT(a_start_root, cmd.start, (sp_q == '0) && (cur_o_q == NW'(1)))

endmodule

// ===== design/range_add_range_max_tree_top.sv =====
// ----------------------------------------------------------------------------
// range_add_range_max_tree_top
// Lazy segment tree: range add and range maximum over signed values.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): operation, range_low, range_high,
// add_value. An add transaction gives no result; a query gives one result
// transaction (max_value, range_empty) on out_valid / out_stall.
// active_length is written through cfg_wr_en / cfg_wr_data; the user must
// do so only while idle, which the block does not enforce. Each transaction
// walks the tree with a frame stack through the single read and write port
// of the two node RAMs: a skipped node is popped, a covered one takes the
// add into its pending value or updates the best, and a split node pushes
// its pending value to both children, visits them and, on an add, pulls
// their maximum back up. A wide range splits up to two nodes a level. A
// query on an empty range, or any item at zero length, is not walked.
// Items go one at a time: in_stall is low only while idle, so the next
// transaction is taken once the walk, and for a query the loading of its
// result, is done. After reset both node RAMs are cleared, one entry a
// cycle, over all 2 * MAX_LEAVES entries; in_stall stays high meanwhile.
// A finished result sits in the output register; the next item is taken
// meanwhile, but a further query result waits while out_stall is high.
// ----------------------------------------------------------------------------
module range_add_range_max_tree_top #(
	parameter int unsigned MAX_LEAVES = rart_pkg::MaxLeavesDef,
	parameter int unsigned VALUE_BITS = rart_pkg::ValueBitsDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [rart_pkg::IdxW-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      operation,
	input  logic [rart_pkg::IdxW-1:0] range_low,
	input  logic [rart_pkg::IdxW-1:0] range_high,
	input  logic [63:0]               add_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [63:0]               max_value,
	output logic                      range_empty
);

	rart_pkg::dp_cmd_t    cmd;
	rart_pkg::dp_status_t sts;

	rart_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_stall  (in_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rart_datapath #(
		.MAX_LEAVES (MAX_LEAVES),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.operation   (operation),
		.range_low   (range_low),
		.range_high  (range_high),
		.add_value   (add_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.max_value   (max_value),
		.range_empty (range_empty)
	);

endmodule

// ===== test/tb_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checker
// Watches the input and result channels of the range-add / range-max tree,
// keeps its own lazy tree over the active elements and compares every result.
// ----------------------------------------------------------------------------
module tb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        operation,
	input  logic [10:0] range_low,
	input  logic [10:0] range_high,
	input  logic [63:0] add_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] max_value,
	input  logic        range_empty,
	output int          fail_count,
	output int          result_count,
	output int          pending_count
);

	localparam int Leaves = 1024;

	typedef struct packed {
		logic [63:0] peak;
		logic        empty;
	} peak_t;

	logic [63:0] tree_max [2*Leaves];
	logic [63:0] tree_add [2*Leaves];
	logic [10:0] cur_len;
	peak_t       peak_q[$];

	function automatic logic [63:0] node_sum(int o);
		if (o >= 2*Leaves)
			return 64'd0;
		return tree_max[o] + tree_add[o];
	endfunction

	function automatic void add_pend(int o, logic [63:0] v);
		if (o < 2*Leaves)
			tree_add[o] = tree_add[o] + v;
	endfunction

	function automatic void push_pend(int o, int l, int r);
		logic [63:0] p;
		if (o >= 2*Leaves)
			return;
		p = tree_add[o];
		tree_max[o] = tree_max[o] + p;
		if (l != r) begin
			add_pend(2*o, p);
			add_pend(2*o+1, p);
		end
		tree_add[o] = 64'd0;
	endfunction

	function automatic void tree_add_range(int o, int l, int r, int lo, int hi,
			logic [63:0] v);
		int mid;
		logic signed [63:0] a, b;
		if (hi < l || lo > r)
			return;
		if (l >= lo && r <= hi) begin
			add_pend(o, v);
			return;
		end
		mid = (l + r) / 2;
		push_pend(o, l, r);
		tree_add_range(2*o, l, mid, lo, hi, v);
		tree_add_range(2*o+1, mid+1, r, lo, hi, v);
		a = node_sum(2*o);
		b = node_sum(2*o+1);
		if (o < 2*Leaves)
			tree_max[o] = (b > a) ? b : a;
	endfunction

	function automatic void tree_peak(int o, int l, int r, int lo, int hi,
			inout logic signed [63:0] best, inout bit found);
		int mid;
		logic signed [63:0] t;
		if (r < lo || l > hi)
			return;
		if (l >= lo && r <= hi) begin
			t = node_sum(o);
			if (!found || t > best)
				best = t;
			found = 1'b1;
			return;
		end
		push_pend(o, l, r);
		mid = (l + r) / 2;
		tree_peak(2*o, l, mid, lo, hi, best, found);
		tree_peak(2*o+1, mid+1, r, lo, hi, best, found);
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%t mismatch %s: got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		int n, lo, hi;
		logic signed [63:0] best;
		bit found;
		peak_t exp_p;
		if (!arst_n) begin
			for (int i = 0; i < 2*Leaves; i++) begin
				tree_max[i] = '0;
				tree_add[i] = '0;
			end
			cur_len = rart_pkg::LenReset;
			peak_q.delete();
			fail_count = 0;
			result_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_wr_en)
				cur_len = cfg_wr_data;
			if (in_valid && !in_stall) begin
				n = (cur_len > Leaves) ? Leaves : cur_len;
				lo = range_low;
				hi = range_high;
				if (operation == rart_pkg::OP_ADD) begin
					if (n > 0)
						tree_add_range(1, 1, n, lo, hi, add_value);
				end else begin
					found = 1'b0;
					best = '0;
					if (n > 0 && ((lo < 1) ? 1 : lo) <= ((hi > n) ? n : hi))
						tree_peak(1, 1, n, lo, hi, best, found);
					exp_p.peak = found ? best : rart_pkg::EmptyMark;
					exp_p.empty = !found;
					peak_q = {peak_q, exp_p};
				end
			end
			if (out_valid && !out_stall) begin
				result_count++;
				if (peak_q.size() == 0) begin
					report("unexpected result", max_value, 64'd0);
				end else begin
					exp_p = peak_q.pop_front();
					if (max_value !== exp_p.peak)
						report("max_value", max_value, exp_p.peak);
					if (range_empty !== exp_p.empty)
						report("range_empty", 64'(range_empty), 64'(exp_p.empty));
				end
			end
			pending_count = peak_q.size();
		end
	end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the range-add / range-max tree: directed corner ranges, then
// random add/query phases under several active lengths with random stalls.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int WatchLimit = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [10:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = rart_pkg::OP_ADD;
	logic [10:0] range_low = 11'd1;
	logic [10:0] range_high = 11'd1;
	logic [63:0] add_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [63:0] max_value;
	logic        range_empty;
	int          fail_count, result_count, pending_count;
	int          idle_cycles = 0;
	int          item_count = 0;
	int          rx_wait = 0;
	bit          rx_took = 1'b0;
	bit          hold_off = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	range_add_range_max_tree_top dut (
		.clk, .arst_n, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_stall,
		.operation, .range_low, .range_high, .add_value,
		.out_valid, .out_stall, .max_value, .range_empty
	);

	tb_checker chk (.*);

	// valid stays high at the end; the next call or the caller drops it
	task automatic send(logic op, int lo, int hi, logic [63:0] v);
		repeat ($urandom_range(0, 5)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		range_low <= lo[10:0];
		range_high <= hi[10:0];
		add_value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		item_count++;
		@(negedge clk);
	endtask

	task automatic drain_and_set(int len);
		while (pending_count != 0)
			@(negedge clk);
		repeat (2000) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= len[10:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [63:0] rand_value();
		case ($urandom_range(0, 3))
			0: return {$urandom, $urandom};
			1: return 64'($signed($urandom_range(0, 2000)) - 1000);
			2: return {{32{$urandom_range(0, 1) == 1}}, $urandom};
			default: return $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF
				: 64'h8000_0000_0000_0000;
		endcase
	endfunction

	// receiver: after each result it stalls for a randomly drawn wait
	always @(posedge clk)
		rx_took <= out_valid && !out_stall;

	always @(negedge clk) begin
		if (rx_took)
			rx_wait = $urandom_range(0, 5);
		if (hold_off || rx_wait != 0)
			out_stall <= 1'b1;
		else
			out_stall <= 1'b0;
		if (!hold_off && rx_wait != 0)
			rx_wait = rx_wait - 1;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("watchdog expired");
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		int lens[6] = '{1024, 1, 0, 2047, 37, 1024};
		int n, lo, hi;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		// directed corners
		send(rart_pkg::OP_QUERY, 1, 1024, 0);
		send(rart_pkg::OP_ADD, 1, 1024, 64'h7FFF_FFFF_FFFF_FFFF);
		send(rart_pkg::OP_QUERY, 1, 1024, 0);
		send(rart_pkg::OP_ADD, 1, 1, 64'd1);
		send(rart_pkg::OP_QUERY, 1, 1, 0);
		send(rart_pkg::OP_QUERY, 1024, 1024, 0);
		send(rart_pkg::OP_ADD, 512, 513, 64'h8000_0000_0000_0000);
		send(rart_pkg::OP_QUERY, 500, 520, 0);
		send(rart_pkg::OP_QUERY, 600, 5, 0);
		send(rart_pkg::OP_ADD, 600, 5, 64'd99);
		send(rart_pkg::OP_QUERY, 0, 0, 0);
		send(rart_pkg::OP_QUERY, 0, 2047, 0);
		send(rart_pkg::OP_ADD, 0, 2047, 64'hF000_0000_0000_0000);
		send(rart_pkg::OP_QUERY, 1025, 2047, 0);
		send(rart_pkg::OP_ADD, 3, 3, 64'hFFFF_FFFF_FFFF_FFFF);
		send(rart_pkg::OP_QUERY, 1, 2047, 0);
		// long receiver hold-off while queries keep being offered
		hold_off = 1'b1;
		fork
			begin
				repeat (3000) @(negedge clk);
				hold_off = 1'b0;
			end
			begin
				for (int i = 0; i < 6; i++)
					send(rart_pkg::OP_QUERY, $urandom_range(1, 1024), 1024, 0);
				in_valid <= 1'b0;
			end
		join
		for (int ph = 0; ph < 6; ph++) begin
			drain_and_set(lens[ph]);
			n = (lens[ph] > 1024) ? 1024 : lens[ph];
			for (int i = 0; i < 140; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					lo = $urandom_range(0, 2047);
					hi = $urandom_range(0, 2047);
				end else begin
					lo = $urandom_range(1, (n > 0) ? n : 1);
					hi = $urandom_range(lo, (n > lo) ? n : lo);
				end
				send($urandom_range(0, 1) ? rart_pkg::OP_QUERY : rart_pkg::OP_ADD,
					lo, hi, rand_value());
			end
			in_valid <= 1'b0;
		end
		while (pending_count != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		$display("%0d items sent, %0d results checked, over six active lengths",
			item_count, result_count);
		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+design
design/rart_pkg.sv
design/rart_ram.sv
design/rart_ctrl.sv
design/rart_datapath.sv
design/range_add_range_max_tree_top.sv
test/tb_checker.sv
test/tb_top.sv
